// ===== rtl/raf_pkg.sv =====
// ----------------------------------------------------------------------------
// raf_pkg
// Shared widths and control types of the running average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package raf_pkg;

  localparam int SAMPLE_W = 32;
  localparam int AVG_W    = 32;

  // divider control from the sequencer
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/raf_sample_if.sv =====
// ----------------------------------------------------------------------------
// raf_sample_if
// Valid/ready channel that carries one input sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface raf_sample_if;

  logic                                valid;
  logic                                ready;
  logic signed [raf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== rtl/raf_average_if.sv =====
// ----------------------------------------------------------------------------
// raf_average_if
// Valid/ready channel that carries one average per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface raf_average_if;

  logic                             valid;
  logic                             ready;
  logic signed [raf_pkg::AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);

endinterface

`default_nettype wire

// ===== rtl/raf_div.sv =====
// ----------------------------------------------------------------------------
// raf_div
// Bit-serial restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module raf_div #(
  parameter int DIVIDEND_W = 37,
  parameter int DIVISOR_W  = 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  raf_pkg::div_ctrl_t           ctrl_i,
  input  wire signed [DIVIDEND_W-1:0]  dividend_i,
  input  wire        [DIVISOR_W-1:0]   divisor_i,
  output raf_pkg::div_stat_t           stat_o,
  output logic signed [DIVIDEND_W-1:0] quotient_o
);

  localparam int ITER_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q, neg_q;
  logic [ITER_W-1:0]     iter_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d, dvs_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVIDEND_W-1:0] mag;

  // magnitude of the dividend; the most negative value maps to itself unsigned
  assign mag = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= ITER_W'(DIVIDEND_W);
    end else if (busy_q) begin
      iter_q <= iter_q - 1'b1;
      if (iter_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ===== rtl/running_average_filter.sv =====
// ----------------------------------------------------------------------------
// running_average_filter
// Moving average over the last WINDOW_SIZE signed 32-bit samples.
// ----------------------------------------------------------------------------
// Each accepted sample replaces the oldest entry of a ring memory, updates a
// running sum and yields one result: the sum divided by the number of samples
// taken so far (saturating at WINDOW_SIZE), truncated toward zero. Until the
// window has filled, the missing entries count as zero. After acceptance the
// sequencer removes the oldest entry from the sum, adds the new sample, launches
// the bit-serial divider, which retires one quotient bit per cycle over the
// SUM_W-bit sum, and loads the result. The input is ready only while
// the sequencer is idle. The result sits in an output register, so a new
// sample is taken while the previous average still waits downstream. No
// clearing pass is needed after reset: the ring is filled in write order, so
// the fill count tells which entries hold data.
// ----------------------------------------------------------------------------
`default_nettype none

module running_average_filter #(
  parameter int WINDOW_SIZE = 20
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  raf_sample_if.sink           smp_i,
  raf_average_if.source        avg_o
);

  localparam int POS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W = raf_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a sample
  localparam logic [2:0] ST_SUB   = 3'd1;  // remove the oldest entry from the sum
  localparam logic [2:0] ST_ADD   = 3'd2;  // add the new sample, store it
  localparam logic [2:0] ST_START = 3'd3;  // launch the divider
  localparam logic [2:0] ST_DIV   = 3'd4;  // wait for quotient, load output

  logic [2:0]                          state_q, state_d;
  logic [POS_W-1:0]                    pos_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic signed [SUM_W-1:0]             sum_q;
  logic signed [raf_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [raf_pkg::SAMPLE_W-1:0] rd_q;
  logic signed [raf_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_SIZE];
  logic signed [SUM_W-1:0]             old_ext;
  logic                                full;
  logic                                in_req;
  logic                                out_load;
  logic                                out_valid_q;
  logic signed [raf_pkg::AVG_W-1:0]    avg_q;
  raf_pkg::div_ctrl_t                  div_ctrl;
  raf_pkg::div_stat_t                  div_stat;
  logic signed [SUM_W-1:0]             div_quo;

  assign in_req  = smp_i.valid && smp_i.ready;
  assign full    = (cnt_q == CNT_W'(WINDOW_SIZE));
  // entries beyond the fill count were never written and count as zero
  assign old_ext = full ? SUM_W'(rd_q) : '0;

  assign smp_i.ready = (state_q == ST_IDLE);

  // output register frees up when the waiting average is taken
  assign out_load = (state_q == ST_DIV) && div_stat.done &&
                    (!out_valid_q || avg_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_req) state_d = ST_SUB;
      ST_SUB:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUB) begin
        sum_q <= sum_q - old_ext;
      end
      if (state_q == ST_ADD) begin
        sum_q <= sum_q + SUM_W'(sample_q);
        pos_q <= (pos_q == POS_W'(WINDOW_SIZE - 1)) ? '0 : pos_q + 1'b1;
        if (!full) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // sample holding register
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      sample_q <= smp_i.sample;
    end
  end

  // ring memory: read the oldest entry on accept, overwrite it with the new sample in the add state
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      rd_q <= ring_mem[pos_q];
    end
    if (state_q == ST_ADD) begin
      ring_mem[pos_q] <= sample_q;
    end
  end

  assign div_ctrl.start = (state_q == ST_START);

  raf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (avg_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q <= div_quo[raf_pkg::AVG_W-1:0];
    end
  end

  assign avg_o.valid   = out_valid_q;
  assign avg_o.average = avg_q;

  // fill count saturates at the window size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= WINDOW_SIZE)
    else $error("fill count beyond window");

  // while filling, the write position tracks the fill count
  a_pos_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> int'(pos_q) == int'(cnt_q))
    else $error("write position out of step with fill count");

  // divider only runs while the sequencer waits for it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIV)
    else $error("divider busy outside divide state");

  // an accepted sample always starts the update sequence
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> state_q == ST_SUB)
    else $error("accepted sample did not start update");

endmodule

`default_nettype wire
